@@ rtl/bpc_pkg.sv @@
// shared constants and types of the byte permutation cipher
`default_nettype none

package bpc_pkg;

    // table geometry
    localparam int TABLE_SIZE = 256;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam int DATA_W     = 8;

    // number of chained table lookups per byte
    localparam int ROUNDS = 3;

    // free-slot search window per build cycle
    localparam int PROBE_W    = 8;
    localparam int PROBE_BITS = $clog2(PROBE_W);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_STEP  = 2'd1;

    // reset key values
    localparam logic [DATA_W-1:0] KEY_START_RST = 8'd0;
    localparam logic [DATA_W-1:0] KEY_STEP_RST  = 8'd1;

    // function codes carried in tuser
    localparam logic FUNC_ENCRYPT = 1'b0;
    localparam logic FUNC_DECRYPT = 1'b1;

    // table build sequencer
    typedef enum logic {
        ST_BUILD,
        ST_RUN
    } build_state_t;

endpackage

`default_nettype wire

@@ rtl/byte_permutation_cipher.sv @@
// keyed byte permutation cipher: table builder and three-round lookup pipeline
`default_nettype none

// Byte substitution cipher. After reset and after every write to key_start or
// key_step the block rebuilds its 256-entry permutation and inverse tables and
// holds s_tready low meanwhile; writes to other indexes are ignored. The build
// searches eight slots per cycle for a free one and places one value per cycle
// while its window holds a free slot; otherwise it moves the window on by eight
// slots. Step 0 and step 1 (the reset keys) find a free slot in every window.
// Once built, one byte is accepted every cycle unless the output stalls
// (s_tuser 0 encrypts with the forward table, 1 decrypts with the inverse,
// three rounds either way). Each round is one registered table read, and each
// stage has its own copy of both tables; the third stage is the output
// register, so each byte passes the stage 0, 1 and 2 registers in turn.
// s_tlast travels with the byte to m_tlast.
// Configuration writes are always taken and are meant only while no byte is in
// flight.
module byte_permutation_cipher (
    input  wire                          clk,
    input  wire                          rst_n,
    // input stream
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [bpc_pkg::DATA_W-1:0]   s_tdata,   // [7:0] data_in
    input  wire                          s_tuser,   // [0] func
    input  wire                          s_tlast,   // block_end
    // output stream
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [bpc_pkg::DATA_W-1:0]   m_tdata,   // [7:0] data_out
    output logic                         m_tlast,   // block_end_out
    // configuration writes
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [bpc_pkg::DATA_W-1:0]   cfg_data
);

    import bpc_pkg::*;

    // key registers and build state
    logic [DATA_W-1:0]     key_start_reg;
    logic [DATA_W-1:0]     key_step_reg;
    build_state_t          state_reg;
    build_state_t          state_next;
    logic [ADDR_W-1:0]     k_reg;
    logic [ADDR_W-1:0]     k_next;
    logic [ADDR_W-1:0]     slot_reg;
    logic [ADDR_W-1:0]     slot_next;
    logic [TABLE_SIZE-1:0] used_reg;
    logic [TABLE_SIZE-1:0] used_next;

    // build datapath
    logic                  cfg_write;
    logic                  free_found;
    logic [PROBE_BITS-1:0] probe_off;
    logic [ADDR_W-1:0]     place_slot;
    logic [DATA_W-1:0]     place_value;
    logic                  place_en;
    logic                  last_value;
    logic                  run_en;

    // lookup pipeline
    logic                  stage_en    [ROUNDS];
    logic                  stage_valid [ROUNDS];
    logic                  stage_func  [ROUNDS];
    logic                  stage_last  [ROUNDS];
    logic [ADDR_W-1:0]     stage_addr  [ROUNDS];
    logic [DATA_W-1:0]     stage_c     [ROUNDS];

    // config channel never stalls
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready
                       && (cfg_index == REG_KEY_START || cfg_index == REG_KEY_STEP);

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_start_reg <= KEY_START_RST;
            key_step_reg  <= KEY_STEP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_KEY_START: key_start_reg <= cfg_data;
                REG_KEY_STEP:  key_step_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // first free slot in the probe window
    always_comb
    begin
        free_found = 1'b0;
        probe_off  = '0;
        for (int i = PROBE_W - 1; i >= 0; i--)
        begin
            if (!used_reg[slot_reg + ADDR_W'(i)])
            begin
                free_found = 1'b1;
                probe_off  = PROBE_BITS'(i);
            end
        end
    end

    assign place_slot  = slot_reg + ADDR_W'(probe_off);
    assign place_value = key_start_reg + DATA_W'(k_reg);
    assign last_value  = (k_reg == ADDR_W'(TABLE_SIZE - 1));

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_BUILD:
            begin
                if (free_found && last_value)
                    state_next = ST_RUN;
            end
            ST_RUN:  state_next = ST_RUN;
            default: state_next = ST_BUILD;
        endcase
        if (cfg_write)
            state_next = ST_BUILD;
    end

    // sequencer outputs
    always_comb
    begin
        place_en = 1'b0;
        run_en   = 1'b0;
        case (state_reg)
            ST_BUILD: place_en = free_found;
            ST_RUN:   run_en   = 1'b1;
            default:  ;
        endcase
    end

    // build counters and slot bookkeeping
    always_comb
    begin
        k_next    = k_reg;
        slot_next = slot_reg;
        used_next = used_reg;
        if (cfg_write)
        begin
            k_next    = '0;
            slot_next = '0;
            used_next = '0;
        end
        else if (place_en)
        begin
            k_next                = k_reg + 1'b1;
            slot_next             = place_slot + key_step_reg;
            used_next[place_slot] = 1'b1;
        end
        else if (state_reg == ST_BUILD)
        begin
            slot_next = slot_reg + ADDR_W'(PROBE_W);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BUILD;
            k_reg     <= '0;
            slot_reg  <= '0;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            slot_reg  <= slot_next;
            used_reg  <= used_next;
        end
    end

    // input side takes a byte when the tables are ready and stage 0 can move
    assign s_tready = run_en && stage_en[0];

    // one lookup stage per round, each with its own copy of both tables
    for (genvar g = 0; g < ROUNDS; g++)
    begin : g_round
        logic [DATA_W-1:0] perm_mem [TABLE_SIZE];
        logic [ADDR_W-1:0] inv_mem  [TABLE_SIZE];
        logic [DATA_W-1:0] perm_q_reg;
        logic [ADDR_W-1:0] inv_q_reg;
        logic              valid_reg;
        logic              func_reg;
        logic              last_reg;
        logic              valid_in;
        logic              func_in;
        logic              last_in;

        // stage enable and source of this stage
        if (g == ROUNDS - 1)
        begin : g_tail
            assign stage_en[g] = !valid_reg || m_tready;
        end
        else
        begin : g_body
            assign stage_en[g] = !valid_reg || stage_en[g+1];
        end

        if (g == 0)
        begin : g_head
            assign stage_addr[g] = s_tdata;
            assign valid_in      = s_tvalid && s_tready;
            assign func_in       = s_tuser;
            assign last_in       = s_tlast;
        end
        else
        begin : g_chain
            assign stage_addr[g] = stage_c[g-1];
            assign valid_in      = stage_valid[g-1];
            assign func_in       = stage_func[g-1];
            assign last_in       = stage_last[g-1];
        end

        // forward table write during build
        always_ff @(posedge clk)
        begin
            if (place_en)
                perm_mem[place_slot] <= place_value;
        end

        // inverse table write during build
        always_ff @(posedge clk)
        begin
            if (place_en)
                inv_mem[place_value] <= place_slot;
        end

        // registered table reads
        always_ff @(posedge clk)
        begin
            if (stage_en[g])
            begin
                perm_q_reg <= perm_mem[stage_addr[g]];
                inv_q_reg  <= inv_mem[stage_addr[g]];
                func_reg   <= func_in;
                last_reg   <= last_in;
            end
        end

        // stage occupancy
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg <= 1'b0;
            else if (stage_en[g])
                valid_reg <= valid_in;
        end

        assign stage_valid[g] = valid_reg;
        assign stage_func[g]  = func_reg;
        assign stage_last[g]  = last_reg;
        assign stage_c[g]     = (func_reg == FUNC_DECRYPT) ? inv_q_reg : perm_q_reg;
    end

    // last stage is the output register
    assign m_tvalid = stage_valid[ROUNDS-1];
    assign m_tdata  = stage_c[ROUNDS-1];
    assign m_tlast  = stage_last[ROUNDS-1];

    // a key write restarts the build from the first value
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> (state_reg == ST_BUILD && k_reg == '0 && used_reg == '0))
        else $error("key write did not restart the table build");

    // a value is never placed on a slot already taken
    assert property (@(posedge clk) disable iff (!rst_n)
        place_en |-> !used_reg[place_slot])
        else $error("build placed a value on a taken slot");

    // the build ends only with every slot filled
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && $past(state_reg) == ST_BUILD) |-> (&used_reg))
        else $error("build finished with free slots left");

    // no byte enters while the tables are being built
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUILD) |-> !s_tready)
        else $error("input accepted during table build");

endmodule

`default_nettype wire

@@ tb/sv/byte_permutation_cipher_checker.sv @@
// stream monitor and predictor of the byte permutation cipher
module byte_permutation_cipher_checker
    import bpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [7:0] data_in
    input  logic              s_tuser,   // [0] func
    input  logic              s_tlast,   // block_end
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [DATA_W-1:0] m_tdata,   // [7:0] data_out
    input  logic              m_tlast,   // block_end_out
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0] cfg_data,
    output int                errors,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic              last;
    } cipher_word_t;

    logic [DATA_W-1:0] key_start;
    logic [DATA_W-1:0] key_step;
    logic [DATA_W-1:0] fwd_table [TABLE_SIZE];
    logic [DATA_W-1:0] inv_table [TABLE_SIZE];
    cipher_word_t      expected_bytes [$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    // place values start, start+1, ... stepping slots and probing forward to a free one
    task automatic rebuild_tables();
        bit                taken [TABLE_SIZE];
        logic [DATA_W-1:0] slot;
        logic [DATA_W-1:0] value;
        int                k;
        slot  = '0;
        value = key_start;
        for (k = 0; k < TABLE_SIZE; k++)
            taken[k] = 1'b0;
        for (k = 0; k < TABLE_SIZE; k++)
        begin
            fwd_table[slot] = value;
            taken[slot]     = 1'b1;
            value           = value + 8'd1;
            if (k < TABLE_SIZE - 1)
            begin
                slot = slot + key_step;
                while (taken[slot])
                    slot = slot + 8'd1;
            end
        end
        for (k = 0; k < TABLE_SIZE; k++)
            inv_table[fwd_table[k]] = k[DATA_W-1:0];
    endtask

    // three chained lookups in the forward or inverse table
    function automatic logic [DATA_W-1:0] cipher_byte(input logic fn,
                                                      input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] c;
        int                r;
        c = b;
        for (r = 0; r < ROUNDS; r++)
            c = (fn == FUNC_DECRYPT) ? inv_table[c] : fwd_table[c];
        return c;
    endfunction

    // watch all three channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        cipher_word_t want;
        if (!rst_n)
        begin
            key_start = KEY_START_RST;
            key_step  = KEY_STEP_RST;
            rebuild_tables();
            expected_bytes.delete();
            pending = 0;
        end
        else
        begin
            // key writes, unknown indexes leave the tables alone
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_KEY_START)
                begin
                    key_start = cfg_data;
                    rebuild_tables();
                end
                else if (cfg_index == REG_KEY_STEP)
                begin
                    key_step = cfg_data;
                    rebuild_tables();
                end
            end

            // accepted input word
            if (s_tvalid && s_tready)
            begin
                want.data = cipher_byte(s_tuser, s_tdata);
                want.last = s_tlast;
                expected_bytes.push_back(want);
            end

            // accepted output word against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: output word data %02h last %0d with nothing pending",
                                 $realtime, m_tdata, m_tlast);
                    errors++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.data || m_tlast !== want.last)
                    begin
                        if (errors < 10)
                            $display("%0t: word mismatch: expected data %02h last %0d, got data %02h last %0d",
                                     $realtime, want.data, want.last, m_tdata, m_tlast);
                        errors++;
                    end
                end
            end
            pending = expected_bytes.size();
        end
    end

endmodule

@@ tb/sv/byte_permutation_cipher_tb.sv @@
// stimulus and verdict for the byte permutation cipher
module byte_permutation_cipher_tb;
    import bpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int WORDS_PER_PHASE = 194;
    localparam int NUM_PHASES      = 8;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic              s_tuser;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0] cfg_data;
    int                errors;
    int                pending;
    int                idle_pct;
    int                stall_pct;

    byte_permutation_cipher DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    byte_permutation_cipher_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    // 8 ns clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit, well past the slowest correct run including the slowest table rebuilds
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // output side back-pressure
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // one input word, with a random gap ahead of it; leaves tvalid high
    task automatic send_word(input logic fn, input logic [DATA_W-1:0] b, input logic last);
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= fn;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop sending and wait for every predicted word to come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // register write once the pipe is empty; leaves cfg_valid high
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // byte extremes in both directions, block end set and clear
    task automatic send_corners();
        send_word(FUNC_ENCRYPT, 8'h00, 1'b0);
        send_word(FUNC_ENCRYPT, 8'hff, 1'b1);
        send_word(FUNC_DECRYPT, 8'h00, 1'b1);
        send_word(FUNC_DECRYPT, 8'hff, 1'b0);
    endtask

    initial
    begin : stimulus
        int                ph;
        int                n;
        int                len;
        int                i;
        bit                paused;
        logic              fn;
        logic [DATA_W-1:0] start_key;
        logic [DATA_W-1:0] step_key;

        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = FUNC_ENCRYPT;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_KEY_START;
        cfg_data  = '0;
        idle_pct  = 0;
        stall_pct = 0;
        rst_n     = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // identity table from the reset keys
        send_corners();
        // top values of both keys
        write_reg(REG_KEY_START, 8'hff);
        write_reg(REG_KEY_STEP, 8'hff);
        send_corners();
        // zero step: every slot found by the forward search
        write_reg(REG_KEY_START, 8'h00);
        write_reg(REG_KEY_STEP, 8'h00);
        send_corners();
        // writes to unused indexes must not disturb the tables
        write_reg(REG_SPARE_2, 8'haa);
        write_reg(REG_SPARE_3, 8'h55);
        send_corners();

        // random buffers under changing keys and flow control
        paused = 1'b0;
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 56; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 56; end
                default: begin idle_pct = 7;  stall_pct = 7;  end
            endcase

            if (ph == 3)
                start_key = 8'h00;
            else if (ph == 6)
                start_key = 8'hff;
            else
                start_key = DATA_W'($urandom_range(255));
            if (ph == 2)
                step_key = 8'h00;
            else if (ph == 5)
                step_key = 8'hff;
            else
                step_key = DATA_W'($urandom_range(255));

            write_reg(REG_KEY_START, start_key);
            write_reg(REG_KEY_STEP, step_key);
            if (ph % 2 == 1)
                write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                          DATA_W'($urandom_range(255)));

            n = 0;
            while (n < WORDS_PER_PHASE)
            begin
                len = $urandom_range(16, 1);
                fn  = $urandom_range(1) ? FUNC_DECRYPT : FUNC_ENCRYPT;
                for (i = 0; i < len; i++)
                    send_word(fn, DATA_W'($urandom_range(255)), i == len - 1);
                n += len;
                // hold the sender once until the output side has caught up
                if (ph == 4 && !paused && n > WORDS_PER_PHASE / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        repeat (16) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
rtl/bpc_pkg.sv
rtl/byte_permutation_cipher.sv
tb/sv/byte_permutation_cipher_checker.sv
tb/sv/byte_permutation_cipher_tb.sv
